@@ sv/pdwt_pkg.sv @@
// Shared types and constants for the weighted Pruefer sequence decoder.
package pdwt_pkg;

  localparam int NODES_MAX   = 64;
  localparam int NODE_BITS   = $clog2(NODES_MAX);
  localparam int CNT_BITS    = NODE_BITS + 1;
  localparam int WEIGHT_BITS = 16;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic [NODE_BITS-1:0]   code_node;
    logic [WEIGHT_BITS-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [NODE_BITS-1:0]   leaf_node;
    logic [NODE_BITS-1:0]   partner_node;
    logic [WEIGHT_BITS-1:0] edge_weight_out;
    logic                   status;
    logic                   last_edge;
  } out_item_t;

  typedef struct packed {
    logic                 found;
    logic [NODE_BITS-1:0] idx;
  } leaf_t;

endpackage

@@ sv/pdwt_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
module pdwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/pdwt_leaf_find.sv @@
// Priority encoder that picks the lowest-index current leaf.
module pdwt_leaf_find (
  input  logic [pdwt_pkg::NODES_MAX-1:0] mask,
  output pdwt_pkg::leaf_t                leaf
);

  always_comb begin
    leaf = '0;
    for (int i = pdwt_pkg::NODES_MAX - 1; i >= 0; i--) begin
      if (mask[i]) begin
        leaf.found = 1'b1;
        leaf.idx   = pdwt_pkg::NODE_BITS'(i);
      end
    end
  end

endmodule

@@ sv/prufer_decode_weighted_tree_core.sv @@
// Top level of the weighted Pruefer sequence decoder: control, memories, result register.
// Loading: S_IDLE takes an item, S_LOAD_WB does the read-modify-write of the degree memory;
// start is ignored while busy. Decode starts on the final item; per code step S_RD_ITEM,
// S_RD_DEG and S_STEP register one edge, then S_FIN1 and S_FIN2 register the closing edge.
// Invalid sequence: one error result in the cycle after the final item, then a degree-memory clear.
// Reset (sync, active low) and every config write start a degree-memory clear; results never stall.
module prufer_decode_weighted_tree_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  pdwt_pkg::in_item_t              in_item,
  output logic                            out_strobe,
  output pdwt_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [pdwt_pkg::CNT_BITS-1:0]   cfg_wdata
);

  localparam int NB = pdwt_pkg::NODE_BITS;
  localparam int CB = pdwt_pkg::CNT_BITS;
  localparam int NM = pdwt_pkg::NODES_MAX;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD_WB,
    S_RD_ITEM,
    S_RD_DEG,
    S_STEP,
    S_FIN1,
    S_FIN2
  } state_t;

  state_t              state_r, state_nxt;
  logic [CB-1:0]       node_count_r, node_count_nxt;
  logic [NB-1:0]       items_r, items_nxt;
  logic                bad_r, bad_nxt;
  logic [NM-1:0]       seen_r, seen_nxt;
  logic [NB-1:0]       clr_r, clr_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  pdwt_pkg::out_item_t out_item_r, out_item_nxt;
  logic [NM-1:0]       mask_r, mask_nxt;
  logic [NB-1:0]       step_r, step_nxt;
  logic [NB-1:0]       u_r, u_nxt;
  logic [pdwt_pkg::WEIGHT_BITS-1:0] w_r, w_nxt;
  logic [NB-1:0]       a_r, a_nxt;

  logic [CB-1:0]       n_eff;
  logic [NM-1:0]       below_n;
  logic [CB-1:0]       n_minus2;

  logic                item_we;
  logic [NB-1:0]       item_waddr, item_raddr;
  pdwt_pkg::in_item_t  item_wdata, item_rdata;
  logic                deg_we;
  logic [NB-1:0]       deg_waddr, deg_raddr;
  logic [NB-1:0]       deg_wdata, deg_rdata;

  pdwt_pkg::leaf_t     leaf;

  pdwt_ram #(
    .WIDTH ($bits(pdwt_pkg::in_item_t)),
    .DEPTH (NM)
  ) u_item_ram (
    .clk   (clk),
    .we    (item_we),
    .waddr (item_waddr),
    .wdata (item_wdata),
    .raddr (item_raddr),
    .rdata (item_rdata)
  );

  pdwt_ram #(
    .WIDTH (NB),
    .DEPTH (NM)
  ) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  pdwt_leaf_find u_leaf_find (
    .mask (mask_r),
    .leaf (leaf)
  );

  always_comb begin
    if (node_count_r < CB'(3)) begin
      n_eff = CB'(3);
    end else if (node_count_r > CB'(NM)) begin
      n_eff = CB'(NM);
    end else begin
      n_eff = node_count_r;
    end
  end

  assign n_minus2 = n_eff - CB'(2);

  always_comb begin
    for (int i = 0; i < NM; i++) begin
      below_n[i] = CB'(i) < n_eff;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    node_count_nxt = node_count_r;
    items_nxt      = items_r;
    bad_nxt        = bad_r;
    seen_nxt       = seen_r;
    clr_nxt        = clr_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    mask_nxt       = mask_r;
    step_nxt       = step_r;
    u_nxt          = u_r;
    w_nxt          = w_r;
    a_nxt          = a_r;
    item_we        = 1'b0;
    item_waddr     = items_r;
    item_wdata     = in_item;
    item_raddr     = '0;
    deg_we         = 1'b0;
    deg_waddr      = '0;
    deg_wdata      = '0;
    deg_raddr      = '0;

    case (state_r)
      S_CLEAR: begin
        deg_we    = 1'b1;
        deg_waddr = clr_r;
        clr_nxt   = clr_r + NB'(1);
        if (clr_r == NB'(NM - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          item_we = 1'b1;
          if ({1'b0, items_r} < n_minus2) begin
            deg_raddr                  = in_item.code_node;
            u_nxt                      = in_item.code_node;
            seen_nxt[in_item.code_node] = 1'b1;
            if ({1'b0, in_item.code_node} >= n_eff) begin
              bad_nxt = 1'b1;
            end
            items_nxt = items_r + NB'(1);
            state_nxt = S_LOAD_WB;
          end else begin
            items_nxt = '0;
            seen_nxt  = '0;
            bad_nxt   = 1'b0;
            if (bad_r) begin
              out_strobe_nxt = 1'b1;
              out_item_nxt   = '0;
              out_item_nxt.status    = pdwt_pkg::STATUS_BAD;
              out_item_nxt.last_edge = 1'b1;
              clr_nxt        = '0;
              state_nxt      = S_CLEAR;
            end else begin
              mask_nxt  = ~seen_r & below_n;
              step_nxt  = '0;
              state_nxt = S_RD_ITEM;
            end
          end
        end
      end
      S_LOAD_WB: begin
        deg_we    = 1'b1;
        deg_waddr = u_r;
        deg_wdata = deg_rdata + NB'(1);
        state_nxt = S_IDLE;
      end
      S_RD_ITEM: begin
        item_raddr = step_r;
        state_nxt  = S_RD_DEG;
      end
      S_RD_DEG: begin
        deg_raddr = item_rdata.code_node;
        u_nxt     = item_rdata.code_node;
        w_nxt     = item_rdata.edge_weight;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        deg_we    = 1'b1;
        deg_waddr = u_r;
        deg_wdata = deg_rdata - NB'(1);
        mask_nxt[leaf.idx] = 1'b0;
        if (deg_rdata == NB'(1)) begin
          mask_nxt[u_r] = 1'b1;
        end
        out_strobe_nxt               = 1'b1;
        out_item_nxt.leaf_node       = leaf.idx;
        out_item_nxt.partner_node    = u_r;
        out_item_nxt.edge_weight_out = w_r;
        out_item_nxt.status          = pdwt_pkg::STATUS_OK;
        out_item_nxt.last_edge       = 1'b0;
        step_nxt = step_r + NB'(1);
        if ({1'b0, step_r} == n_eff - CB'(3)) begin
          state_nxt = S_FIN1;
        end else begin
          state_nxt = S_RD_ITEM;
        end
      end
      S_FIN1: begin
        item_raddr         = n_minus2[NB-1:0];
        a_nxt              = leaf.idx;
        mask_nxt[leaf.idx] = 1'b0;
        state_nxt          = S_FIN2;
      end
      S_FIN2: begin
        out_strobe_nxt               = 1'b1;
        out_item_nxt.leaf_node       = a_r;
        out_item_nxt.partner_node    = leaf.idx;
        out_item_nxt.edge_weight_out = item_rdata.edge_weight;
        out_item_nxt.status          = pdwt_pkg::STATUS_OK;
        out_item_nxt.last_edge       = 1'b1;
        state_nxt                    = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase

    if (cfg_we) begin
      node_count_nxt = cfg_wdata;
      items_nxt      = '0;
      bad_nxt        = 1'b0;
      seen_nxt       = '0;
      clr_nxt        = '0;
      state_nxt      = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      node_count_r <= CB'(NM);
      items_r      <= '0;
      bad_r        <= 1'b0;
      seen_r       <= '0;
      clr_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_count_r <= node_count_nxt;
      items_r      <= items_nxt;
      bad_r        <= bad_nxt;
      seen_r       <= seen_nxt;
      clr_r        <= clr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    mask_r     <= mask_nxt;
    step_r     <= step_nxt;
    u_r        <= u_nxt;
    w_r        <= w_nxt;
    a_r        <= a_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

`ifndef NO_ASSERTIONS
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.status == pdwt_pkg::STATUS_BAD |-> out_item.last_edge)
    else $error("error transaction without last_edge");

  a_leaf_present: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP || state_r == S_FIN1 || state_r == S_FIN2 |-> leaf.found)
    else $error("no leaf available during decode");

  a_deg_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |-> deg_rdata != '0)
    else $error("degree count underflow");

  a_leaf_not_code: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |-> leaf.idx != u_r)
    else $error("leaf equals its partner");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back result transactions");
`endif

endmodule
